### hw/rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types, constants and helpers of the RPN stack evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 64;
    localparam int OPND_W      = 32;
    localparam int ERR_W       = 3;

    localparam logic signed [DATA_W-1:0] OPERAND_MIN = -64'sd2147483648;
    localparam logic signed [DATA_W-1:0] OPERAND_MAX = 64'sd2147483647;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 3'd1;
    localparam logic [ERR_W-1:0] ERR_RANGE     = 3'd2;
    localparam logic [ERR_W-1:0] ERR_DIVZERO   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_DEPTH     = 3'd4;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 3'd5;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_B,
        ST_CHECK,
        ST_EXEC,
        ST_RD_0,
        ST_EMIT
    } t_state;

    function automatic logic out_of_range(input logic signed [DATA_W-1:0] v);
        return (v <= OPERAND_MIN) || (v >= OPERAND_MAX);
    endfunction

    function automatic logic is_operator(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
    endfunction

endpackage

### hw/rtl/rpn_in_if.sv
// ----------------------------------------------------------------------------
// rpn_in_if
// Character channel: one expression character per transfer.
// ----------------------------------------------------------------------------
interface rpn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

### hw/rtl/rpn_out_if.sv
// ----------------------------------------------------------------------------
// rpn_out_if
// Result channel: final value and error code per expression.
// ----------------------------------------------------------------------------
interface rpn_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rpn_pkg::DATA_W-1:0]    value;
    logic        [rpn_pkg::ERR_W-1:0]     error;

    modport source (output valid, output value, output error, input ready);
    modport sink   (input valid, input value, input error, output ready);
endinterface

### hw/rtl/rpn_ram.sv
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module rpn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/rpn_alu.sv
// ----------------------------------------------------------------------------
// rpn_alu
// Shared arithmetic unit: registered add/sub/mul, bit-serial signed divide.
// ----------------------------------------------------------------------------
module rpn_alu (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rpn_pkg::t_alu_req                   i_req,
    input  logic signed [rpn_pkg::OPND_W-1:0]   i_a,
    input  logic signed [rpn_pkg::OPND_W-1:0]   i_b,
    output logic                                o_done,
    output logic signed [rpn_pkg::DATA_W-1:0]   o_result
);

    localparam int W     = rpn_pkg::OPND_W;
    localparam int CNT_W = $clog2(W);

    logic                              r_busy;
    logic                              r_done;
    logic [CNT_W-1:0]                  r_cnt;
    logic [W-1:0]                      r_rem;
    logic [W-1:0]                      r_quo;
    logic [W-1:0]                      r_div;
    logic                              r_neg;
    logic signed [rpn_pkg::DATA_W-1:0] r_result;

    logic signed [rpn_pkg::DATA_W-1:0] a_ext;
    logic signed [rpn_pkg::DATA_W-1:0] b_ext;
    logic signed [rpn_pkg::DATA_W-1:0] fast_result;
    logic [W-1:0]                      a_mag;
    logic [W-1:0]                      b_mag;
    logic [W-1:0]                      rem_sh;
    logic [W:0]                        diff;
    logic                              q_bit;
    logic [W-1:0]                      n_rem;
    logic [W-1:0]                      n_quo;
    logic signed [W-1:0]               q_signed;

    assign a_ext = rpn_pkg::DATA_W'(i_a);
    assign b_ext = rpn_pkg::DATA_W'(i_b);
    assign a_mag = i_a[W-1] ? W'(-i_a) : W'(i_a);
    assign b_mag = i_b[W-1] ? W'(-i_b) : W'(i_b);

    always_comb begin
        unique case (i_req.op)
            rpn_pkg::ALU_ADD: fast_result = b_ext + a_ext;
            rpn_pkg::ALU_SUB: fast_result = b_ext - a_ext;
            rpn_pkg::ALU_MUL: fast_result = i_b * i_a;
            default:          fast_result = '0;
        endcase
    end

    // one restoring step
    assign rem_sh   = {r_rem[W-2:0], r_quo[W-1]};
    assign diff     = {1'b0, rem_sh} - {1'b0, r_div};
    assign q_bit    = ~diff[W];
    assign n_rem    = q_bit ? diff[W-1:0] : rem_sh;
    assign n_quo    = {r_quo[W-2:0], q_bit};
    assign q_signed = r_neg ? $signed(-n_quo) : $signed(n_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (i_req.op == rpn_pkg::ALU_DIV) begin
                    r_busy <= 1'b1;
                end else begin
                    r_done <= 1'b1;
                end
            end else if (r_busy && (r_cnt == CNT_W'(W - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt    <= '0;
            r_rem    <= '0;
            r_quo    <= b_mag;
            r_div    <= a_mag;
            r_neg    <= i_a[W-1] ^ i_b[W-1];
            r_result <= fast_result;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            r_rem <= n_rem;
            r_quo <= n_quo;
            if (r_cnt == CNT_W'(W - 1)) begin
                r_result <= rpn_pkg::DATA_W'(q_signed);
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

### hw/rtl/rpn_stack_evaluator_core.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_core
// Reverse Polish notation calculator fed one character per transfer.
//
//   channel   dir   payload              transfer
//   i_in      in    ch[7:0], last        valid & ready
//   o_out     out   value[63:0], error   valid & ready
//
// Space, digit, other byte, latched error or operator on a short stack:
// taken in idle alone. + - * /: two stack reads, check, then ALU unless
// the check fails; / gives one quotient bit per cycle in the shared ALU.
// Last character adds a read of stack bottom and the result register.
// Ready only in idle; a result waits in the output register, and the
// next result stalls until it is taken. Synchronous active-low reset.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rpn_in_if.sink     i_in,
    rpn_out_if.source  o_out
);

    localparam int PW = rpn_pkg::PTR_W;
    localparam int DW = rpn_pkg::DEPTH_W;

    rpn_pkg::t_state                   r_state, n_state;
    logic [DW-1:0]                     r_depth, n_depth;
    logic [rpn_pkg::ERR_W-1:0]         r_err, n_err;
    logic [7:0]                        r_ch, n_ch;
    logic                              r_last, n_last;
    logic signed [rpn_pkg::DATA_W-1:0] r_a, n_a;

    logic                              r_out_valid;
    logic signed [rpn_pkg::DATA_W-1:0] r_out_value;
    logic [rpn_pkg::ERR_W-1:0]         r_out_error;
    logic                              out_load;
    logic                              out_free;

    logic                              ram_we, ram_re;
    logic [PW-1:0]                     ram_waddr, ram_raddr;
    logic [rpn_pkg::DATA_W-1:0]        ram_wdata, ram_rdata;

    rpn_pkg::t_alu_req                 alu_req;
    rpn_pkg::t_alu_op                  alu_op;
    logic                              alu_done;
    logic signed [rpn_pkg::DATA_W-1:0] alu_result;

    logic [DW-1:0]                     depth_m1, depth_m2;
    logic                              in_op, in_work, op_go, chk_err;
    logic signed [rpn_pkg::DATA_W-1:0] b_val;

    assign depth_m1 = r_depth - DW'(1);
    assign depth_m2 = r_depth - DW'(2);
    assign in_op    = rpn_pkg::is_operator(i_in.ch);
    assign in_work  = (r_err == rpn_pkg::ERR_NONE) && (i_in.ch != rpn_pkg::CH_SPACE);
    assign op_go    = in_work && in_op && (r_depth >= DW'(2));
    assign b_val    = $signed(ram_rdata);
    assign chk_err  = rpn_pkg::out_of_range(r_a) || rpn_pkg::out_of_range(b_val) ||
                      ((alu_op == rpn_pkg::ALU_DIV) && (r_a == '0));
    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        unique case (r_ch)
            rpn_pkg::CH_PLUS:  alu_op = rpn_pkg::ALU_ADD;
            rpn_pkg::CH_MINUS: alu_op = rpn_pkg::ALU_SUB;
            rpn_pkg::CH_STAR:  alu_op = rpn_pkg::ALU_MUL;
            default:           alu_op = rpn_pkg::ALU_DIV;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rpn_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    if (op_go) begin
                        n_state = rpn_pkg::ST_RD_B;
                    end else if (i_in.last) begin
                        n_state = rpn_pkg::ST_RD_0;
                    end
                end
            end
            rpn_pkg::ST_RD_B: n_state = rpn_pkg::ST_CHECK;
            rpn_pkg::ST_CHECK: begin
                if (!chk_err) begin
                    n_state = rpn_pkg::ST_EXEC;
                end else begin
                    n_state = r_last ? rpn_pkg::ST_RD_0 : rpn_pkg::ST_IDLE;
                end
            end
            rpn_pkg::ST_EXEC: begin
                if (alu_done) begin
                    n_state = r_last ? rpn_pkg::ST_RD_0 : rpn_pkg::ST_IDLE;
                end
            end
            rpn_pkg::ST_RD_0: n_state = rpn_pkg::ST_EMIT;
            rpn_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = rpn_pkg::ST_IDLE;
                end
            end
            default: n_state = rpn_pkg::ST_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        i_in.ready    = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = r_depth[PW-1:0];
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = '0;
        alu_req.start = 1'b0;
        alu_req.op    = alu_op;
        out_load      = 1'b0;
        n_depth       = r_depth;
        n_err         = r_err;
        n_ch          = r_ch;
        n_last        = r_last;
        n_a           = r_a;
        unique case (r_state)
            rpn_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_ch   = i_in.ch;
                    n_last = i_in.last;
                    if (in_work) begin
                        if (in_op) begin
                            if (r_depth < DW'(2)) begin
                                n_err = rpn_pkg::ERR_UNDERFLOW;
                            end else begin
                                ram_re    = 1'b1;
                                ram_raddr = depth_m1[PW-1:0];
                            end
                        end else if (r_depth == DW'(rpn_pkg::STACK_DEPTH)) begin
                            n_err = rpn_pkg::ERR_OVERFLOW;
                        end else begin
                            ram_we  = 1'b1;
                            n_depth = r_depth + DW'(1);
                            if ((i_in.ch >= rpn_pkg::CH_ZERO) &&
                                (i_in.ch <= rpn_pkg::CH_NINE)) begin
                                ram_wdata = rpn_pkg::DATA_W'(i_in.ch - rpn_pkg::CH_ZERO);
                            end
                        end
                    end
                end
            end
            rpn_pkg::ST_RD_B: begin
                ram_re    = 1'b1;
                ram_raddr = depth_m2[PW-1:0];
                n_a       = $signed(ram_rdata);
            end
            rpn_pkg::ST_CHECK: begin
                if (rpn_pkg::out_of_range(r_a) || rpn_pkg::out_of_range(b_val)) begin
                    n_err = rpn_pkg::ERR_RANGE;
                end else if (chk_err) begin
                    n_err = rpn_pkg::ERR_DIVZERO;
                end else begin
                    alu_req.start = 1'b1;
                end
            end
            rpn_pkg::ST_EXEC: begin
                if (alu_done) begin
                    ram_we    = 1'b1;
                    ram_waddr = depth_m2[PW-1:0];
                    ram_wdata = alu_result;
                    n_depth   = depth_m1;
                end
            end
            rpn_pkg::ST_RD_0: begin
                ram_re = 1'b1;
                if ((r_err == rpn_pkg::ERR_NONE) && (r_depth != DW'(1))) begin
                    n_err = rpn_pkg::ERR_DEPTH;
                end
            end
            rpn_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_depth  = '0;
                    n_err    = rpn_pkg::ERR_NONE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rpn_pkg::ST_IDLE;
            r_depth     <= '0;
            r_err       <= rpn_pkg::ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_err   <= n_err;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ch   <= n_ch;
        r_last <= n_last;
        r_a    <= n_a;
        if (out_load) begin
            r_out_value <= (r_err == rpn_pkg::ERR_NONE) ? $signed(ram_rdata) : '0;
            r_out_error <= r_err;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.value = r_out_value;
    assign o_out.error = r_out_error;

    rpn_ram #(
        .WIDTH (rpn_pkg::DATA_W),
        .DEPTH (rpn_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rpn_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (alu_req),
        .i_a      (r_a[rpn_pkg::OPND_W-1:0]),
        .i_b      (b_val[rpn_pkg::OPND_W-1:0]),
        .o_done   (alu_done),
        .o_result (alu_result)
    );

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(rpn_pkg::STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_err_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_error != rpn_pkg::ERR_NONE)) |-> (r_out_value == '0))
        else $error("result value not zero with error");

    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> ((r_depth == '0) && (r_err == rpn_pkg::ERR_NONE)))
        else $error("stack not cleared after result");

    a_alu_done_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> (r_state == rpn_pkg::ST_EXEC))
        else $error("ALU completion outside execute");
`endif

endmodule

### bench/rpn_stack_evaluator_core_tb.sv
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_core_tb
// Self-checking bench for the RPN stack evaluator. Expressions go in one
// character per transfer, and a cycle-free model of the stack predicts each
// final value and error code. The expressions are directed cases, then random
// well-formed expressions, operands built up to the 32-bit limits, stack
// overflows, broken sequences and raw byte noise. Both channels idle at
// random, with one long result stall and drain pauses.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         QUIET_LIMIT  = 20000;
    localparam int         TAIL_CYCLES  = 100;
    localparam int         CHAR_BUDGET  = 1650;
    localparam int         HOLD_AT      = 40;
    localparam int         HOLD_CYCLES  = 3000;
    localparam logic [7:0] LETTER_FIRST = 8'h61;
    localparam logic [7:0] LETTER_LAST  = 8'h7A;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         drain;
    } t_expr_char;

    typedef struct {
        logic signed [rpn_pkg::DATA_W-1:0] value;
        logic        [rpn_pkg::ERR_W-1:0]  error;
    } t_rpn_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rpn_in_if  in_if ();
    rpn_out_if out_if ();

    rpn_stack_evaluator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_expr_char  expr_chars[$];
    t_rpn_result expected_results[$];

    logic signed [rpn_pkg::DATA_W-1:0] calc_stack [rpn_pkg::STACK_DEPTH];
    int                                calc_depth = 0;
    logic        [rpn_pkg::ERR_W-1:0]  calc_err   = rpn_pkg::ERR_NONE;

    int fail_count   = 0;
    int delivered    = 0;
    int quiet_cycles = 0;
    int burst_left   = 1;
    int gap_left     = 0;
    int hold_left    = 0;
    int rx_cycle     = 0;
    bit hold_done    = 1'b0;
    bit in_took      = 1'b0;

    function automatic void flag_fail(string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("ERROR: %s", msg);
        end
    endfunction

    // Stack calculator: one character in, a result queued on the last one.
    task automatic eval_char(input logic [7:0] ch, input logic last);
        logic signed [rpn_pkg::DATA_W-1:0] a;
        logic signed [rpn_pkg::DATA_W-1:0] b;
        logic signed [rpn_pkg::DATA_W-1:0] r;
        logic signed [rpn_pkg::DATA_W-1:0] nxt;
        t_rpn_result                       res;
        if (calc_err == rpn_pkg::ERR_NONE) begin
            case (ch)
                rpn_pkg::CH_SPACE: begin
                end
                rpn_pkg::CH_PLUS, rpn_pkg::CH_MINUS, rpn_pkg::CH_STAR,
                rpn_pkg::CH_SLASH: begin
                    if (calc_depth < 2) begin
                        calc_err = rpn_pkg::ERR_UNDERFLOW;
                    end else begin
                        a = calc_stack[calc_depth-1];
                        b = calc_stack[calc_depth-2];
                        if (a <= rpn_pkg::OPERAND_MIN || a >= rpn_pkg::OPERAND_MAX ||
                            b <= rpn_pkg::OPERAND_MIN || b >= rpn_pkg::OPERAND_MAX) begin
                            calc_err = rpn_pkg::ERR_RANGE;
                        end else if (ch == rpn_pkg::CH_SLASH && a == 0) begin
                            calc_err = rpn_pkg::ERR_DIVZERO;
                        end else begin
                            case (ch)
                                rpn_pkg::CH_PLUS:  r = b + a;
                                rpn_pkg::CH_MINUS: r = b - a;
                                rpn_pkg::CH_STAR:  r = b * a;
                                default:           r = b / a;
                            endcase
                            calc_stack[calc_depth-2] = r;
                            calc_depth--;
                        end
                    end
                end
                default: begin
                    nxt = (ch >= rpn_pkg::CH_ZERO && ch <= rpn_pkg::CH_NINE) ?
                          rpn_pkg::DATA_W'(ch - rpn_pkg::CH_ZERO) : '0;
                    if (calc_depth >= rpn_pkg::STACK_DEPTH) begin
                        calc_err = rpn_pkg::ERR_OVERFLOW;
                    end else begin
                        calc_stack[calc_depth] = nxt;
                        calc_depth++;
                    end
                end
            endcase
        end
        if (last) begin
            if (calc_err == rpn_pkg::ERR_NONE && calc_depth != 1) begin
                calc_err = rpn_pkg::ERR_DEPTH;
            end
            res.value = (calc_err == rpn_pkg::ERR_NONE) ? calc_stack[0] : '0;
            res.error = calc_err;
            expected_results.push_back(res);
            calc_depth = 0;
            calc_err   = rpn_pkg::ERR_NONE;
        end
    endtask

    // ---- stimulus builders ----
    function automatic void add_char(input logic [7:0] c);
        t_expr_char item;
        item.ch    = c;
        item.last  = 1'b0;
        item.drain = 1'b0;
        expr_chars.push_back(item);
    endfunction

    function automatic void close_expr();
        expr_chars[expr_chars.size()-1].last = 1'b1;
    endfunction

    function automatic void add_drain();
        t_expr_char item;
        item.ch    = rpn_pkg::CH_SPACE;
        item.last  = 1'b0;
        item.drain = 1'b1;
        expr_chars.push_back(item);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_char(s[i]);
        end
        close_expr();
    endfunction

    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 3))
            0:       return rpn_pkg::CH_PLUS;
            1:       return rpn_pkg::CH_MINUS;
            2:       return rpn_pkg::CH_STAR;
            default: return rpn_pkg::CH_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'($urandom_range(rpn_pkg::CH_ZERO, rpn_pkg::CH_NINE));
    endfunction

    // Builds a non-negative number digit by digit: x = x * 10 + d.
    function automatic void add_number(input longint v);
        string s;
        s = $sformatf("%0d", v);
        add_char(s[0]);
        for (int i = 1; i < s.len(); i++) begin
            add_char(rpn_pkg::CH_NINE);
            add_char(rpn_pkg::CH_ZERO + 8'd1);
            add_char(rpn_pkg::CH_PLUS);
            add_char(rpn_pkg::CH_STAR);
            add_char(s[i]);
            add_char(rpn_pkg::CH_PLUS);
        end
    endfunction

    function automatic void add_wellformed();
        int n;
        int cap;
        int d;
        cap = ($urandom_range(0, 15) == 0) ? rpn_pkg::STACK_DEPTH + 2 : $urandom_range(2, 6);
        n   = (cap > 8) ? $urandom_range(30, 45) : $urandom_range(1, 24);
        d   = 0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                add_char(rpn_pkg::CH_SPACE);
            end
            if (d < 2 || (d < cap && $urandom_range(0, 1) == 1)) begin
                if ($urandom_range(0, 9) == 0) begin
                    add_char(8'($urandom_range(LETTER_FIRST, LETTER_LAST)));
                end else begin
                    add_char(pick_digit());
                end
                d++;
            end else begin
                add_char(pick_op());
                d--;
            end
        end
        while (d > 1) begin
            add_char(pick_op());
            d--;
        end
        close_expr();
    endfunction

    // Operands at and around the 32-bit limits, either sign.
    function automatic void add_big_operand();
        longint v;
        bit     neg;
        case ($urandom_range(0, 3))
            0:       v = 64'd2147483647 - $urandom_range(0, 3);
            1:       v = 64'd2147483648 + $urandom_range(0, 3);
            2:       v = $urandom_range(0, 32'h7FFFFFFF);
            default: v = 64'd2147483647;
        endcase
        neg = 1'($urandom_range(0, 1));
        if (neg) begin
            add_char(rpn_pkg::CH_ZERO);
        end
        add_number(v);
        if (neg) begin
            add_char(rpn_pkg::CH_MINUS);
        end
        repeat ($urandom_range(0, 2)) begin
            add_char(($urandom_range(0, 1) == 1) ? rpn_pkg::CH_ZERO + 8'd1 : pick_digit());
            add_char(pick_op());
        end
        close_expr();
    endfunction

    function automatic void add_overflow();
        repeat ($urandom_range(rpn_pkg::STACK_DEPTH - 1, rpn_pkg::STACK_DEPTH + 3)) begin
            add_char(pick_digit());
        end
        repeat ($urandom_range(0, 3)) begin
            add_char(pick_op());
        end
        close_expr();
    endfunction

    function automatic void add_broken();
        repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 3))
                0:       add_char(pick_op());
                1:       add_char(pick_digit());
                2:       add_char(rpn_pkg::CH_SPACE);
                default: add_char(8'($urandom_range(0, 255)));
            endcase
        end
        close_expr();
    endfunction

    function automatic void add_noise();
        repeat ($urandom_range(1, 4)) begin
            add_char(8'($urandom_range(0, 255)));
        end
        close_expr();
    endfunction

    // ---- sender: bursts and gaps, pauses at drain marks ----
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (in_if.valid && !in_took) begin
            // offer stays up until the transfer
        end else if (gap_left > 0) begin
            gap_left--;
            in_if.valid <= 1'b0;
        end else if (expr_chars.size() != 0 && expr_chars[0].drain) begin
            in_if.valid <= 1'b0;
            if (expected_results.size() == 0) begin
                void'(expr_chars.pop_front());
            end
        end else if (expr_chars.size() != 0) begin
            in_if.valid <= 1'b1;
            in_if.ch    <= expr_chars[0].ch;
            in_if.last  <= expr_chars[0].last;
            if (burst_left > 1) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
        end else begin
            in_if.valid <= 1'b0;
        end
    end

    // ---- receiver: stall pattern by window, one long hold ----
    always @(negedge i_clk) begin
        rx_cycle++;
        if (!hold_done && delivered >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            case ((rx_cycle / 97) % 4)
                0:       out_if.ready <= 1'b1;
                1:       out_if.ready <= 1'($urandom_range(0, 1));
                2:       out_if.ready <= (rx_cycle % 5) < 2;
                default: out_if.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // ---- transfers in, prediction, result check ----
    always @(posedge i_clk) begin : monitor
        t_rpn_result want;
        in_took = i_rst_n && in_if.valid && in_if.ready;
        if (in_took) begin
            eval_char(in_if.ch, in_if.last);
            void'(expr_chars.pop_front());
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            delivered++;
            if (expected_results.size() == 0) begin
                flag_fail($sformatf("result %0d with none expected: value %0d error %0d",
                                    delivered, out_if.value, out_if.error));
            end else begin
                want = expected_results.pop_front();
                if (out_if.value !== want.value || out_if.error !== want.error) begin
                    flag_fail($sformatf(
                        "result %0d: value exp %0d got %0d, error exp %0d got %0d",
                        delivered, want.value, out_if.value, want.error, out_if.error));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.ch     = '0;
        in_if.last   = 1'b0;
        out_if.ready = 1'b0;

        // directed: each operator, truncation, errors, byte extremes
        add_text("34+");
        add_text("92-");
        add_text("76*");
        add_text("72/");
        add_text("29-4/");
        add_text("-");
        add_text("50/");
        add_text(" ");
        add_text("12");
        add_text("a");
        add_char(8'h00);
        close_expr();
        add_char(8'hFF);
        close_expr();
        add_drain();

        while (expr_chars.size() < CHAR_BUDGET) begin
            if (expr_chars.size() > CHAR_BUDGET / 2 && expr_chars.size() < CHAR_BUDGET / 2 + 40)
            begin
                add_drain();
            end
            case ($urandom_range(0, 99)) inside
                [0:54]:  add_wellformed();
                [55:69]: add_big_operand();
                [70:77]: add_overflow();
                [78:89]: add_broken();
                default: add_noise();
            endcase
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (expr_chars.size() != 0 || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_in_if.sv
hw/rtl/rpn_out_if.sv
hw/rtl/rpn_ram.sv
hw/rtl/rpn_alu.sv
hw/rtl/rpn_stack_evaluator_core.sv
bench/rpn_stack_evaluator_core_tb.sv
